[rtl/pfc_pkg.sv]
`default_nettype none

package pfc_pkg;

    localparam int PIXEL_W = 32;
    localparam int CHAN_W  = 8;
    localparam int FMT_W   = 5;
    localparam int REG_IDX_W = 2;

    // format numbers, in format-table order
    typedef enum logic [FMT_W-1:0] {
        FMT_INVALID   = 5'd0,
        FMT_PAL8      = 5'd1,
        FMT_GRAY8     = 5'd2,
        FMT_RGB555    = 5'd3,
        FMT_BGR555    = 5'd4,
        FMT_RGB565    = 5'd5,
        FMT_BGR565    = 5'd6,
        FMT_ARGB4444  = 5'd7,
        FMT_ARGB1555  = 5'd8,
        FMT_RGB24     = 5'd9,
        FMT_BGR24     = 5'd10,
        FMT_YUV24     = 5'd11,
        FMT_RGBX32    = 5'd12,
        FMT_XRGB32    = 5'd13,
        FMT_BGRX32    = 5'd14,
        FMT_XBGR32    = 5'd15,
        FMT_RGBA32    = 5'd16,
        FMT_ARGB32    = 5'd17,
        FMT_BGRA32    = 5'd18,
        FMT_ABGR32    = 5'd19,
        FMT_WAVELET   = 5'd20,
        FMT_INVALID_2 = 5'd21
    } fmt_t;

    // configuration register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_SOURCE_FORMAT = 2'd0,
        REG_TARGET_FORMAT = 2'd1
    } reg_idx_t;

    // unpacked channels plus a flag for a source that could be decoded
    typedef struct packed {
        logic              ok;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } chan_t;

endpackage

`default_nettype wire

[rtl/pfc_unpack.sv]
`default_nettype none

module pfc_unpack (
    input  wire pfc_pkg::fmt_t                   fmt,
    input  wire logic [pfc_pkg::PIXEL_W-1:0]     pixel,
    output pfc_pkg::chan_t                       chan
);
    import pfc_pkg::*;

    logic [CHAN_W-1:0] b0, b1, b2, b3;

    assign b0 = pixel[7:0];
    assign b1 = pixel[15:8];
    assign b2 = pixel[23:16];
    assign b3 = pixel[31:24];

    // narrow fields land at the top of the byte; colour low bits carry the half-step bias, alpha low bits are zero
    always_comb begin
        chan = '{ok: 1'b1, red: '0, green: '0, blue: '0, alpha: 8'hFF};
        unique case (fmt) inside
            FMT_GRAY8: begin
                chan.red   = b0;
                chan.green = b0;
                chan.blue  = b0;
            end
            FMT_RGB555: begin
                chan.red   = {pixel[14:10], 3'b100};
                chan.green = {pixel[9:5], 3'b100};
                chan.blue  = {pixel[4:0], 3'b100};
            end
            FMT_BGR555: begin
                chan.blue  = {pixel[14:10], 3'b100};
                chan.green = {pixel[9:5], 3'b100};
                chan.red   = {pixel[4:0], 3'b100};
            end
            FMT_RGB565: begin
                chan.red   = {pixel[15:11], 3'b100};
                chan.green = {pixel[10:5], 2'b10};
                chan.blue  = {pixel[4:0], 3'b100};
            end
            FMT_BGR565: begin
                chan.blue  = {pixel[15:11], 3'b100};
                chan.green = {pixel[10:5], 2'b10};
                chan.red   = {pixel[4:0], 3'b100};
            end
            FMT_ARGB4444: begin
                chan.alpha = {pixel[15:12], 4'b0000};
                chan.red   = {pixel[11:8], 4'b1000};
                chan.green = {pixel[7:4], 4'b1000};
                chan.blue  = {pixel[3:0], 4'b1000};
            end
            FMT_ARGB1555: begin
                chan.alpha = {pixel[15], 7'b0000000};
                chan.red   = {pixel[14:10], 3'b100};
                chan.green = {pixel[9:5], 3'b100};
                chan.blue  = {pixel[4:0], 3'b100};
            end
            FMT_RGB24, FMT_YUV24, FMT_XRGB32: begin
                chan.red   = b2;
                chan.green = b1;
                chan.blue  = b0;
            end
            FMT_BGR24, FMT_XBGR32: begin
                chan.blue  = b2;
                chan.green = b1;
                chan.red   = b0;
            end
            FMT_RGBX32: begin
                chan.red   = b3;
                chan.green = b2;
                chan.blue  = b1;
            end
            FMT_BGRX32: begin
                chan.blue  = b3;
                chan.green = b2;
                chan.red   = b1;
            end
            FMT_RGBA32: begin
                chan.red   = b3;
                chan.green = b2;
                chan.blue  = b1;
                chan.alpha = b0;
            end
            FMT_ARGB32: begin
                chan.alpha = b3;
                chan.red   = b2;
                chan.green = b1;
                chan.blue  = b0;
            end
            FMT_BGRA32: begin
                chan.blue  = b3;
                chan.green = b2;
                chan.red   = b1;
                chan.alpha = b0;
            end
            FMT_ABGR32: begin
                chan.alpha = b3;
                chan.blue  = b2;
                chan.green = b1;
                chan.red   = b0;
            end
            default: begin
                chan = '{ok: 1'b0, red: '0, green: '0, blue: '0, alpha: '0};
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/pfc_pack.sv]
`default_nettype none

module pfc_pack (
    input  wire pfc_pkg::fmt_t                   fmt,
    input  wire pfc_pkg::chan_t                  chan,
    output logic [pfc_pkg::PIXEL_W-1:0]          pixel,
    output logic                                 ok
);
    import pfc_pkg::*;

    logic [CHAN_W-1:0] r, g, b, a;
    logic [CHAN_W-1:0] max_rg, gray;

    assign r = chan.red;
    assign g = chan.green;
    assign b = chan.blue;
    assign a = chan.alpha;

    assign max_rg = (r > g) ? r : g;
    assign gray   = (max_rg > b) ? max_rg : b;

    always_comb begin
        ok = 1'b1;
        unique case (fmt) inside
            FMT_GRAY8:    pixel = {24'd0, gray};
            FMT_RGB555:   pixel = {17'd0, r[7:3], g[7:3], b[7:3]};
            FMT_BGR555:   pixel = {17'd0, b[7:3], g[7:3], r[7:3]};
            FMT_RGB565:   pixel = {16'd0, r[7:3], g[7:2], b[7:3]};
            FMT_BGR565:   pixel = {16'd0, b[7:3], g[7:2], r[7:3]};
            FMT_ARGB4444: pixel = {16'd0, a[7:4], r[7:4], g[7:4], b[7:4]};
            FMT_ARGB1555: pixel = {16'd0, a[7], r[7:3], g[7:3], b[7:3]};
            FMT_RGB24, FMT_YUV24, FMT_XRGB32:
                          pixel = {8'd0, r, g, b};
            FMT_BGR24, FMT_XBGR32:
                          pixel = {8'd0, b, g, r};
            FMT_RGBX32:   pixel = {r, g, b, 8'd0};
            FMT_BGRX32:   pixel = {b, g, r, 8'd0};
            FMT_RGBA32:   pixel = {r, g, b, a};
            FMT_ARGB32:   pixel = {a, r, g, b};
            FMT_BGRA32:   pixel = {b, g, r, a};
            FMT_ABGR32:   pixel = {a, b, g, r};
            default: begin
                pixel = '0;
                ok    = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/pixel_format_converter.sv]
`default_nettype none
// path from input accept to result accept: input register, then result register;
//   m_valid rises once the item has been loaded into the result register
// throughput: one item per cycle, sustained while m_ready stays high
// unpack and pack sit as one short combinational pass between the two registers
// reset (aresetn low, synchronous): both pipeline stages empty, both formats set to 0
// configuration writes take effect on the next clock edge

module pixel_format_converter (
    input  wire                                   aclk,
    input  wire                                   aresetn,

    // configuration write port
    input  wire                                   cfg_wr_en,
    input  wire logic [pfc_pkg::REG_IDX_W-1:0]    cfg_index,
    input  wire logic [pfc_pkg::FMT_W-1:0]        cfg_wdata,

    // input items
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire logic [pfc_pkg::PIXEL_W-1:0]      s_in_pixel,

    // result items
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [pfc_pkg::PIXEL_W-1:0]           m_out_pixel,
    output logic [pfc_pkg::CHAN_W-1:0]            m_red,
    output logic [pfc_pkg::CHAN_W-1:0]            m_green,
    output logic [pfc_pkg::CHAN_W-1:0]            m_blue,
    output logic [pfc_pkg::CHAN_W-1:0]            m_alpha,
    output logic                                  m_unsupported
);
    import pfc_pkg::*;

    // format registers
    logic [FMT_W-1:0]   src_fmt_reg;
    logic [FMT_W-1:0]   dst_fmt_reg;

    // input stage
    logic               in_valid_reg;
    logic [PIXEL_W-1:0] in_pixel_reg;

    // result stage
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_pixel_reg,  out_pixel_next;
    logic [CHAN_W-1:0]  out_red_reg;
    logic [CHAN_W-1:0]  out_green_reg;
    logic [CHAN_W-1:0]  out_blue_reg;
    logic [CHAN_W-1:0]  out_alpha_reg;
    logic               out_unsup_reg,  out_unsup_next;

    chan_t              chan;
    logic [PIXEL_W-1:0] packed_pixel;
    logic               pack_ok;
    logic               out_free;     // result stage can take an item this cycle
    logic               out_load;     // item moves from input stage to result stage
    logic               in_take;      // item accepted from s_

    assign out_free = !out_valid_reg || m_ready;
    assign out_load = in_valid_reg && out_free;
    // input stage frees up whenever its item moves on, so a new item enters every cycle unless the result stage stalls
    assign s_ready  = !in_valid_reg || out_free;
    assign in_take  = s_valid && s_ready;

    // config writes; indexes past the register list are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_fmt_reg <= '0;
            dst_fmt_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SOURCE_FORMAT: src_fmt_reg <= cfg_wdata;
                REG_TARGET_FORMAT: dst_fmt_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_pixel_reg <= s_in_pixel;
        end
    end

    // decode the source word to 8-bit channels
    pfc_unpack u_unpack (
        .fmt   (fmt_t'(src_fmt_reg)),
        .pixel (in_pixel_reg),
        .chan  (chan)
    );

    // encode channels in the target format
    pfc_pack u_pack (
        .fmt   (fmt_t'(dst_fmt_reg)),
        .chan  (chan),
        .pixel (packed_pixel),
        .ok    (pack_ok)
    );

    // an undecodable source or an unencodable target forces the result to the unsupported case with a zero pixel
    always_comb begin
        out_unsup_next = !(chan.ok && pack_ok);
        out_pixel_next = out_unsup_next ? '0 : packed_pixel;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_pixel_reg <= out_pixel_next;
            out_red_reg   <= chan.red;
            out_green_reg <= chan.green;
            out_blue_reg  <= chan.blue;
            out_alpha_reg <= chan.alpha;
            out_unsup_reg <= out_unsup_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_pixel   = out_pixel_reg;
    assign m_red         = out_red_reg;
    assign m_green       = out_green_reg;
    assign m_blue        = out_blue_reg;
    assign m_alpha       = out_alpha_reg;
    assign m_unsupported = out_unsup_reg;

    // an unsupported result never carries a packed word
    a_unsup_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_unsup_reg |-> out_pixel_reg == '0)
        else $error("unsupported result with nonzero pixel");

    // an accepted item lands in the input stage
    a_in_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> in_valid_reg && in_pixel_reg == $past(s_in_pixel))
        else $error("accepted item not captured");

    // a blocked item in the input stage is kept unchanged
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_pixel_reg))
        else $error("stalled input stage item lost or changed");

    // an item moving on always shows up as a result next cycle
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg)
        else $error("item dropped between stages");

endmodule

`default_nettype wire
